// ===== hdl/tgdf_pkg.sv =====
// shared types and constants for the thousands-grouped decimal formatter
// no dependencies; imported by tgdf_digit_cell and the top level
package tgdf_pkg;

  // input word width and derived decimal digit count (floor of width * log10 2, plus one)
  localparam int ValueWidth = 32;
  localparam int NumDigits  = (ValueWidth * 30103) / 100000 + 1;
  localparam int DigIdxW    = $clog2(NumDigits);
  localparam int BitCntW    = $clog2(ValueWidth);

  // configuration register indexes
  localparam logic [1:0] CfgSuffixEnable = 2'd0;
  localparam logic [1:0] CfgSeparator    = 2'd1;
  localparam logic [1:0] CfgSuffixChar   = 2'd2;

  // register reset values and fixed characters
  localparam logic [7:0] SeparatorReset = 8'd46;
  localparam logic [7:0] SuffixReset    = 8'd100;
  localparam logic [7:0] CharZero       = 8'h30;
  localparam logic [7:0] CharMinus      = 8'h2d;

  // phase of a digit within its three-digit group
  localparam logic [1:0] GroupLast = 2'd2;

  typedef enum logic [2:0] {
    StIdle,
    StConv,
    StLead,
    StSign,
    StDigit,
    StSep,
    StSuffix
  } state_e;

  // control shared by every cell of the digit chain
  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctrl_t;

endpackage

// ===== hdl/tgdf_digit_cell.sv =====
// one bcd digit cell of the shift-and-add-3 conversion chain
// depends on tgdf_pkg for cell_ctrl_t
module tgdf_digit_cell import tgdf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  logic       bit_i,
  output logic       carry_o,
  output logic [3:0] digit_o
);

  logic [3:0] digit_q, digit_d;
  logic [3:0] adj;

  // add 3 when the digit would overflow after doubling
  always_comb begin
    adj = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
    carry_o = adj[3];
    digit_d = digit_q;
    if (ctrl_i.clear) begin
      digit_d = 4'd0;
    end else if (ctrl_i.shift) begin
      digit_d = {adj[2:0], bit_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= 4'd0;
    end else begin
      digit_q <= digit_d;
    end
  end

  assign digit_o = digit_q;

endmodule

// ===== hdl/thousands_grouped_decimal_formatter_unit.sv =====
// a request runs through conversion of all ValueWidth input bits, a lead-digit state, then one character
// per cycle, up to 15 characters; busy stays high through the last character
// the shift-and-add-3 digit chain sets the conversion time: one input bit per cycle
// one request at a time; the next request is taken in the cycle after the last character
// results are strobed for one cycle each and cannot be stalled
// asynchronous active-low reset clears control state and restores register defaults
module thousands_grouped_decimal_formatter_unit import tgdf_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [ValueWidth-1:0] value_i,
  output logic                  text_valid_o,
  output logic [7:0]            text_char_o,
  output logic                  last_char_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_index_i,
  input  logic [7:0]            cfg_data_i
);

  // configuration registers
  logic       sfx_en_q;
  logic [7:0] sep_q, sfx_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sfx_en_q <= 1'b0;
      sep_q    <= SeparatorReset;
      sfx_q    <= SuffixReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgSuffixEnable: sfx_en_q <= cfg_data_i[0];
        CfgSeparator:    sep_q    <= cfg_data_i;
        CfgSuffixChar:   sfx_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // control and working registers
  state_e              state_q, state_d;
  logic [BitCntW-1:0]  cnt_q, cnt_d;
  logic [DigIdxW-1:0]  k_q, k_d;
  logic [1:0]          ph_q, ph_d;
  logic                neg_q, neg_d;
  logic [ValueWidth-1:0] mag_q, mag_d;

  logic       accept;
  cell_ctrl_t cell_ctrl;
  logic [3:0] digits [NumDigits];
  logic [NumDigits:0] chain;

  assign accept = start && !busy;
  assign busy   = (state_q != StIdle);

  // digit chain, least significant cell first
  assign chain[0] = mag_q[ValueWidth-1];
  for (genvar g = 0; g < NumDigits; g++) begin : g_cell
    tgdf_digit_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (cell_ctrl),
      .bit_i   (chain[g]),
      .carry_o (chain[g+1]),
      .digit_o (digits[g])
    );
  end

  // most significant nonzero digit and its group phase
  logic [DigIdxW-1:0] msd;
  logic [1:0]         msd_ph;
  logic [1:0]         ph_c;
  always_comb begin
    msd    = '0;
    msd_ph = '0;
    ph_c   = '0;
    for (int i = 0; i < NumDigits; i++) begin
      if (digits[i] != 4'd0) begin
        msd    = DigIdxW'(i);
        msd_ph = ph_c;
      end
      ph_c = (ph_c == GroupLast) ? 2'd0 : ph_c + 2'd1;
    end
  end

  // next state and outputs
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    k_d          = k_q;
    ph_d         = ph_q;
    neg_d        = neg_q;
    mag_d        = mag_q;
    cell_ctrl    = '0;
    text_valid_o = 1'b0;
    text_char_o  = CharZero;
    last_char_o  = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          neg_d           = value_i[ValueWidth-1];
          mag_d           = value_i[ValueWidth-1] ? (~value_i + 1'b1) : value_i;
          cnt_d           = '0;
          cell_ctrl.clear = 1'b1;
          state_d         = StConv;
        end
      end
      StConv: begin
        cell_ctrl.shift = 1'b1;
        mag_d           = {mag_q[ValueWidth-2:0], 1'b0};
        cnt_d           = cnt_q + 1'b1;
        if (cnt_q == BitCntW'(ValueWidth - 1)) begin
          state_d = StLead;
        end
      end
      StLead: begin
        k_d     = msd;
        ph_d    = msd_ph;
        state_d = neg_q ? StSign : StDigit;
      end
      StSign: begin
        text_valid_o = 1'b1;
        text_char_o  = CharMinus;
        state_d      = StDigit;
      end
      StDigit: begin
        text_valid_o = 1'b1;
        text_char_o  = CharZero + {4'd0, digits[k_q]};
        if (k_q == '0) begin
          last_char_o = !sfx_en_q;
          state_d     = sfx_en_q ? StSuffix : StIdle;
        end else begin
          k_d = k_q - 1'b1;
          if (ph_q == 2'd0) begin
            ph_d    = GroupLast;
            state_d = StSep;
          end else begin
            ph_d = ph_q - 2'd1;
          end
        end
      end
      StSep: begin
        text_valid_o = 1'b1;
        text_char_o  = sep_q;
        state_d      = StDigit;
      end
      StSuffix: begin
        text_valid_o = 1'b1;
        text_char_o  = sfx_q;
        last_char_o  = 1'b1;
        state_d      = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    k_q   <= k_d;
    ph_q  <= ph_d;
    neg_q <= neg_d;
    mag_q <= mag_d;
  end

  // checks
  a_no_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> !text_valid_o)
    else $error("character strobe while idle");

  a_last_has_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_char_o |-> text_valid_o)
    else $error("last flag without strobe");

  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (text_valid_o && last_char_o) |=> !busy)
    else $error("still busy after last character");

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy && !text_valid_o))
    else $error("request not taken into conversion");

  a_strobe_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy && !$past(busy) && $past(rst_ni)) |-> !text_valid_o)
    else $error("character strobed before conversion");

endmodule
